/* rtl/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and codes for the pixel blend / adjust datapath.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int PIX_W    = 8;
    localparam int MODE_W   = 3;
    localparam int CHAN_W   = 2;
    localparam int AMOUNT_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int NUM_LANES  = 3;

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_MULTIPLY  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCREEN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUBTRACT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERLAY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADD       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_REPLICATE = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT  = 2'd2;

    // channel codes, also the lane numbers
    localparam logic [CHAN_W-1:0] CHAN_BLUE  = 2'd0;
    localparam logic [CHAN_W-1:0] CHAN_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_RED   = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] top_blue;
        logic [PIX_W-1:0] top_green;
        logic [PIX_W-1:0] top_red;
        logic [PIX_W-1:0] bottom_blue;
        logic [PIX_W-1:0] bottom_green;
        logic [PIX_W-1:0] bottom_red;
    } in_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
    } out_beat_t;

    // per-stage load enables handed to the lanes
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pba_ctl_t;

endpackage

/* rtl/pba_lane.sv */
// ----------------------------------------------------------------------------
// pba_lane
// One color channel: operand prep and multiply, divide-by-255 estimate,
// then rounding correction and final select. Three register stages.
// ----------------------------------------------------------------------------
module pba_lane (
    input  logic                                aclk,
    input  pba_pkg::pba_ctl_t                   ctl,
    input  logic [pba_pkg::MODE_W-1:0]          mode,
    input  logic [pba_pkg::AMOUNT_W-1:0]        amount,
    input  logic [pba_pkg::PIX_W-1:0]           top_i,
    input  logic [pba_pkg::PIX_W-1:0]           bot_i,
    output logic [pba_pkg::PIX_W-1:0]           res_o,
    output logic [pba_pkg::PIX_W-1:0]           top_o
);
    import pba_pkg::*;

    localparam logic [1:0] SEL_DIV = 2'd0;
    localparam logic [1:0] SEL_DIR = 2'd1;
    localparam logic [1:0] SEL_SCL = 2'd2;

    // stage 1 ----------------------------------------------------------------
    logic [7:0]         op_a;
    logic [7:0]         op_b;
    logic [9:0]         mul_b;
    logic               dbl;
    logic               inv;
    logic [1:0]         sel;
    logic [7:0]         dir;
    logic signed [10:0] add_sum;
    logic signed [18:0] prod;

    logic signed [18:0] prod1_reg;
    logic [7:0]         dir1_reg;
    logic [7:0]         top1_reg;
    logic [1:0]         sel1_reg;
    logic               dbl1_reg;
    logic               inv1_reg;

    always_comb begin
        op_a    = top_i;
        op_b    = bot_i;
        dbl     = 1'b0;
        inv     = 1'b0;
        sel     = SEL_DIR;
        dir     = top_i;
        add_sum = $signed({3'b000, top_i}) + $signed({amount[AMOUNT_W-1], amount});
        case (mode)
            MODE_MULTIPLY: begin
                sel = SEL_DIV;
            end
            MODE_SCREEN: begin
                // 255 - x is ~x on 8 bits
                op_a = ~top_i;
                op_b = ~bot_i;
                inv  = 1'b1;
                sel  = SEL_DIV;
            end
            MODE_SUBTRACT: begin
                dir = (top_i > bot_i) ? (top_i - bot_i) : 8'd0;
            end
            MODE_OVERLAY: begin
                sel = SEL_DIV;
                dbl = 1'b1;
                if (bot_i[7]) begin
                    op_a = ~top_i;
                    op_b = ~bot_i;
                    inv  = 1'b1;
                end
            end
            MODE_ADD: begin
                if (add_sum < 11'sd0) begin
                    dir = 8'd0;
                end else if (add_sum > 11'sd255) begin
                    dir = 8'd255;
                end else begin
                    dir = add_sum[7:0];
                end
            end
            MODE_SCALE: begin
                sel = SEL_SCL;
            end
            default: begin
                sel = SEL_DIR;
            end
        endcase
        mul_b = (mode == MODE_SCALE) ? amount : {2'b00, op_b};
        prod  = $signed({1'b0, op_a}) * $signed(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            prod1_reg <= prod;
            dir1_reg  <= dir;
            top1_reg  <= top_i;
            sel1_reg  <= sel;
            dbl1_reg  <= dbl;
            inv1_reg  <= inv;
        end
    end

    // stage 2: n = x + 127, quotient estimate floor(n*257 / 2^16) ------------
    logic [17:0] n_wide;
    logic [24:0] n_mul;
    logic [7:0]  scl;
    logic [7:0]  dir2_next;

    logic [16:0] n2_reg;
    logic [8:0]  qe2_reg;
    logic [7:0]  dir2_reg;
    logic [7:0]  top2_reg;
    logic        div2_reg;
    logic        inv2_reg;

    always_comb begin
        n_wide = (dbl1_reg ? {prod1_reg[16:0], 1'b0} : {1'b0, prod1_reg[16:0]}) + 18'd127;
        n_mul  = {n_wide[16:0], 8'd0} + {8'd0, n_wide[16:0]};
        if (prod1_reg[18]) begin
            scl = 8'd0;
        end else if (|prod1_reg[17:8]) begin
            scl = 8'd255;
        end else begin
            scl = prod1_reg[7:0];
        end
        dir2_next = (sel1_reg == SEL_SCL) ? scl : dir1_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            n2_reg   <= n_wide[16:0];
            qe2_reg  <= n_mul[24:16];
            dir2_reg <= dir2_next;
            top2_reg <= top1_reg;
            div2_reg <= (sel1_reg == SEL_DIV);
            inv2_reg <= inv1_reg;
        end
    end

    // stage 3: estimate is low by at most one ---------------------------------
    logic [16:0] qe_x255;
    logic [17:0] rem;
    logic [8:0]  q;
    logic [7:0]  res3_next;

    logic [7:0]  res3_reg;
    logic [7:0]  top3_reg;

    always_comb begin
        qe_x255   = {qe2_reg, 8'd0} - {8'd0, qe2_reg};
        rem       = {1'b0, n2_reg} - {1'b0, qe_x255};
        q         = qe2_reg + {8'd0, (rem >= 18'd255)};
        if (div2_reg) begin
            res3_next = inv2_reg ? ~q[7:0] : q[7:0];
        end else begin
            res3_next = dir2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            res3_reg <= res3_next;
            top3_reg <= top2_reg;
        end
    end

    assign res_o = res3_reg;
    assign top_o = top3_reg;

endmodule

/* rtl/pba_merge.sv */
// ----------------------------------------------------------------------------
// pba_merge
// Combines the three lane results with the pass-through pixel according to
// mode and selected channel, into the output register.
// ----------------------------------------------------------------------------
module pba_merge (
    input  logic                                            aclk,
    input  logic                                            ld,
    input  logic [pba_pkg::MODE_W-1:0]                      mode,
    input  logic [pba_pkg::CHAN_W-1:0]                      chan_sel,
    input  logic [pba_pkg::NUM_LANES-1:0][pba_pkg::PIX_W-1:0] lane_res,
    input  logic [pba_pkg::NUM_LANES-1:0][pba_pkg::PIX_W-1:0] lane_top,
    output pba_pkg::out_beat_t                              m_beat
);
    import pba_pkg::*;

    logic [NUM_LANES-1:0][PIX_W-1:0] pix;
    logic                            chan_ok;
    out_beat_t                       out_reg;

    always_comb begin
        pix     = lane_top;
        chan_ok = (chan_sel == CHAN_BLUE) || (chan_sel == CHAN_GREEN) ||
                  (chan_sel == CHAN_RED);
        if (mode inside {MODE_MULTIPLY, MODE_SCREEN, MODE_SUBTRACT, MODE_OVERLAY}) begin
            pix = lane_res;
        end else if (chan_ok) begin
            if (mode inside {MODE_ADD, MODE_SCALE}) begin
                pix[chan_sel] = lane_res[chan_sel];
            end else if (mode == MODE_REPLICATE) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    pix[i] = lane_top[chan_sel];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            out_reg.out_blue  <= pix[CHAN_BLUE];
            out_reg.out_green <= pix[CHAN_GREEN];
            out_reg.out_red   <= pix[CHAN_RED];
        end
    end

    assign m_beat = out_reg;

endmodule

/* rtl/pixel_blend_adjust_top.sv */
// ----------------------------------------------------------------------------
// pixel_blend_adjust_top
// Per-pixel blend (multiply, screen, subtract, overlay) and single-channel
// adjust (add, scale, replicate) for 8-bit BGR pixels, one lane per channel.
//
//   channel   dir  handshake             payload
//   s_        in   s_valid / s_ready     in_beat_t  (top and bottom BGR)
//   m_        out  m_valid / m_ready     out_beat_t (result BGR)
//   cfg_      in   cfg_we                cfg_index, cfg_data
//
// One beat per clock sustained while m_ready stays high; an accepted beat
// passes four registers before m_valid rises: three lane stages (multiply,
// divide-by-255 estimate, rounding correction) and the merge/output register.
// Reset is synchronous on aresetn and clears the config and all valid bits.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles are squeezed out under m_ready backpressure.
// ----------------------------------------------------------------------------
module pixel_blend_adjust_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pba_pkg::in_beat_t                   s_beat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pba_pkg::out_beat_t                  m_beat,
    input  logic                                cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pba_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pba_pkg::*;

    logic [MODE_W-1:0]   mode_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [AMOUNT_W-1:0] amount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_MULTIPLY;
            chan_reg   <= CHAN_BLUE;
            amount_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:    mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_CHANNEL: chan_reg   <= cfg_data[CHAN_W-1:0];
                CFG_AMOUNT:  amount_reg <= cfg_data[AMOUNT_W-1:0];
                default:     ;
            endcase
        end
    end

    // pipeline valid bits and backward ready chain
    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    logic     rdy1, rdy2, rdy3, rdy4;
    pba_ctl_t ctl;

    always_comb begin
        rdy4    = !v4_reg || m_ready;
        rdy3    = !v3_reg || rdy4;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        ctl.ld1 = rdy1;
        ctl.ld2 = rdy2;
        ctl.ld3 = rdy3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    logic [NUM_LANES-1:0][PIX_W-1:0] top_px;
    logic [NUM_LANES-1:0][PIX_W-1:0] bot_px;
    logic [NUM_LANES-1:0][PIX_W-1:0] lane_res;
    logic [NUM_LANES-1:0][PIX_W-1:0] lane_top;

    always_comb begin
        top_px[CHAN_BLUE]  = s_beat.top_blue;
        top_px[CHAN_GREEN] = s_beat.top_green;
        top_px[CHAN_RED]   = s_beat.top_red;
        bot_px[CHAN_BLUE]  = s_beat.bottom_blue;
        bot_px[CHAN_GREEN] = s_beat.bottom_green;
        bot_px[CHAN_RED]   = s_beat.bottom_red;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pba_lane u_lane (
            .aclk   (aclk),
            .ctl    (ctl),
            .mode   (mode_reg),
            .amount (amount_reg),
            .top_i  (top_px[g]),
            .bot_i  (bot_px[g]),
            .res_o  (lane_res[g]),
            .top_o  (lane_top[g])
        );
    end

    pba_merge u_merge (
        .aclk     (aclk),
        .ld       (rdy4),
        .mode     (mode_reg),
        .chan_sel (chan_reg),
        .lane_res (lane_res),
        .lane_top (lane_top),
        .m_beat   (m_beat)
    );

endmodule

/* rtl/pba_checker.sv */
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks on the blend/adjust top: reset, stall hold, bubble
// squeeze and latency under a free-running sink.
// ----------------------------------------------------------------------------
module pba_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input pba_pkg::out_beat_t     m_beat
);
    import pba_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("output beat changed while stalled");

    // an empty output register means the whole chain can move
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output register empty");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("beat did not reach output in four cycles");

endmodule

bind pixel_blend_adjust_top pba_checker u_pba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_beat  (m_beat)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_blend_adjust_top. A driver streams BGR pixel
// pairs in random bursts while the output side stalls on its own pattern;
// every beat leaving the block is checked against a blend computed here from
// the current mode, channel and amount settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int PIX_MAX       = 255;
    localparam int NUM_PHASES    = 40;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 300000;

    // codes the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
    localparam logic [CHAN_W-1:0] CHAN_SPARE = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_beat    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_beat;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // settings as the block should currently hold them
    logic [MODE_W-1:0]          mode_cfg   = MODE_MULTIPLY;
    logic [CHAN_W-1:0]          chan_cfg   = CHAN_BLUE;
    logic signed [AMOUNT_W-1:0] amount_cfg = '0;

    in_beat_t  pixels_to_send [$];
    out_beat_t expected_pixels [$];
    out_beat_t want;

    int errors      = 0;
    int cycle_count = 0;
    int beats_out   = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int hold_left   = 0;
    int pat_left    = 0;
    int ready_pct   = 100;
    bit long_hold_done = 1'b0;

    logic [AMOUNT_W-1:0] amount_edges [9] = '{10'h200, 10'h300, 10'h3FF, 10'd0, 10'd1,
                                               10'd2, 10'd255, 10'd256, 10'h1FF};

    pixel_blend_adjust_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // round(x / 255); x/255 never sits on a half
    function automatic int div255_round(int x);
        return (2 * x + PIX_MAX) / (2 * PIX_MAX);
    endfunction

    function automatic int clamp_byte(int v);
        if (v < 0) return 0;
        if (v > PIX_MAX) return PIX_MAX;
        return v;
    endfunction

    function automatic int blend_lane(logic [MODE_W-1:0] m, int t, int b);
        case (m)
            MODE_MULTIPLY: return div255_round(t * b);
            MODE_SCREEN:   return PIX_MAX - div255_round((PIX_MAX - t) * (PIX_MAX - b));
            MODE_SUBTRACT: return (t > b) ? t - b : 0;
            MODE_OVERLAY: begin
                if (b <= 127) return div255_round(2 * t * b);
                return PIX_MAX - div255_round(2 * (PIX_MAX - t) * (PIX_MAX - b));
            end
            default:       return t;
        endcase
    endfunction

    function automatic out_beat_t blend_pixel(in_beat_t px);
        int top [NUM_LANES];
        int bot [NUM_LANES];
        int res [NUM_LANES];
        int ofs;
        int c;
        out_beat_t o;
        top[0] = int'(px.top_blue);
        top[1] = int'(px.top_green);
        top[2] = int'(px.top_red);
        bot[0] = int'(px.bottom_blue);
        bot[1] = int'(px.bottom_green);
        bot[2] = int'(px.bottom_red);
        for (int i = 0; i < NUM_LANES; i++) res[i] = top[i];
        if (mode_cfg <= MODE_OVERLAY) begin
            for (int i = 0; i < NUM_LANES; i++) res[i] = blend_lane(mode_cfg, top[i], bot[i]);
        end else if (chan_cfg <= CHAN_RED) begin
            // one-image modes; an unused channel code leaves the top pixel as is
            c = int'(chan_cfg);
            ofs = amount_cfg;
            case (mode_cfg)
                MODE_ADD:       res[c] = clamp_byte(top[c] + ofs);
                MODE_SCALE:     res[c] = clamp_byte(top[c] * ofs);
                MODE_REPLICATE: for (int i = 0; i < NUM_LANES; i++) res[i] = top[c];
                default:        ;
            endcase
        end
        o.out_blue  = PIX_W'(res[0]);
        o.out_green = PIX_W'(res[1]);
        o.out_red   = PIX_W'(res[2]);
        return o;
    endfunction

    function automatic logic [PIX_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return PIX_W'(127 + $urandom_range(0, 1));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic in_beat_t make_pixel(int tb, int tg, int tr, int bb, int bg, int br);
        in_beat_t px;
        px.top_blue     = PIX_W'(tb);
        px.top_green    = PIX_W'(tg);
        px.top_red      = PIX_W'(tr);
        px.bottom_blue  = PIX_W'(bb);
        px.bottom_green = PIX_W'(bg);
        px.bottom_red   = PIX_W'(br);
        return px;
    endfunction

    task automatic queue_pixel(in_beat_t px);
        pixels_to_send.insert(pixels_to_send.size(), px);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(logic [MODE_W-1:0] m, logic [CHAN_W-1:0] ch,
                              logic [AMOUNT_W-1:0] amt);
        write_reg(CFG_MODE, CFG_DATA_W'(m));
        write_reg(CFG_CHANNEL, CFG_DATA_W'(ch));
        write_reg(CFG_AMOUNT, amt);
        mode_cfg   = m;
        chan_cfg   = ch;
        amount_cfg = amt;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pixels_to_send.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_corner_pixels();
        queue_pixel(make_pixel(255, 128, 1, 127, 128, 255));
        queue_pixel(make_pixel(0, 255, 127, 0, 255, 128));
        wait_idle();
    endtask

    initial begin
        int                  n;
        logic [MODE_W-1:0]   m;
        logic [CHAN_W-1:0]   ch;
        logic [AMOUNT_W-1:0] amt;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings first, then every blend mode on the same pixels
        for (int k = 0; k <= MODE_OVERLAY; k++) begin
            if (k != 0) set_config(MODE_W'(k), CHAN_BLUE, 10'd0);
            queue_pixel(make_pixel(0, 0, 0, 255, 255, 255));
            send_corner_pixels();
        end
        set_config(MODE_ADD, CHAN_RED, 10'd256);
        send_corner_pixels();
        set_config(MODE_SCALE, CHAN_GREEN, 10'h3FF);
        send_corner_pixels();
        set_config(MODE_REPLICATE, CHAN_RED, 10'd0);
        send_corner_pixels();
        set_config(MODE_SPARE, CHAN_BLUE, 10'd2);
        send_corner_pixels();
        set_config(MODE_SCALE, CHAN_SPARE, 10'd2);
        send_corner_pixels();

        // random phases, the first eight sweep all mode codes
        for (int p = 0; p < NUM_PHASES; p++) begin
            n  = $urandom_range(10, 87);
            m  = MODE_W'((p < 8) ? p : $urandom_range(0, 7));
            ch = CHAN_W'($urandom_range(0, 3));
            amt = $urandom_range(0, 1) ? amount_edges[$urandom_range(0, 8)]
                                       : AMOUNT_W'($urandom_range(0, 1023));
            set_config(m, ch, amt);
            repeat (n) begin
                queue_pixel(make_pixel(rand_byte(), rand_byte(), rand_byte(),
                                       rand_byte(), rand_byte(), rand_byte()));
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // driver: bursts of beats with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pixels.insert(expected_pixels.size(), blend_pixel(s_beat));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixels_to_send.size() != 0) begin
                    s_beat  <= pixels_to_send.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 63);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: duty-cycle pattern plus one long hold-off to back up the pipe
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!long_hold_done && beats_out >= 200 && pixels_to_send.size() >= 16) begin
            long_hold_done <= 1'b1;
            hold_left      <= 150;
            m_ready        <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_left <= $urandom_range(16, 96);
                case ($urandom_range(0, 4))
                    0, 1:    ready_pct <= 100;
                    2:       ready_pct <= 75;
                    3:       ready_pct <= 50;
                    default: ready_pct <= 20;
                endcase
            end else begin
                pat_left <= pat_left - 1;
            end
            m_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_out <= beats_out + 1;
            if (expected_pixels.size() == 0) begin
                $error("output beat %h with no pixel pending", m_beat);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_beat.out_blue !== want.out_blue) begin
                    $error("out_blue: expected %0d, actual %0d", want.out_blue, m_beat.out_blue);
                    errors++;
                end
                if (m_beat.out_green !== want.out_green) begin
                    $error("out_green: expected %0d, actual %0d",
                           want.out_green, m_beat.out_green);
                    errors++;
                end
                if (m_beat.out_red !== want.out_red) begin
                    $error("out_red: expected %0d, actual %0d", want.out_red, m_beat.out_red);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
